// ===== hdl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  // Map geometry
  localparam int MAP_BITS  = 32768;
  localparam int MAP_WORDS = MAP_BITS / 32;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = WADDR_W + 5;   // bit index into the map
  localparam int CNT_W     = IDX_W + 1;     // bit count in use, up to MAP_BITS
  localparam int PTR_W     = WADDR_W + 1;   // word pointer, up to MAP_WORDS

  // Request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;
  localparam logic [1:0] KIND_TOTAL = 2'd3;

  // Response status codes
  localparam logic [1:0] STS_DONE     = 2'd0;
  localparam logic [1:0] STS_NO_SPACE = 2'd1;
  localparam logic [1:0] STS_RANGE    = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 4;
  localparam logic [3:0] CFG_FIRST_BLOCK = 4'd0;
  localparam logic [3:0] CFG_BIT_COUNT   = 4'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic       req_ready;
    logic       clr_step;
    logic       scan_rd;
    logic       alloc_commit;
    logic       rmw_rd;
    logic       rmw_wr;
    logic       set_total;
    logic       sts_set;
    logic [1:0] sts_code;
    logic       out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_kind;
    logic [1:0] req_kind;
    logic       clr_last;
    logic       scan_hit;
    logic       scan_end;
    logic       in_range;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/bba_req_if.sv =====
`default_nettype none
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] block_number;
  logic [9:0]  word_index;
  logic [31:0] word_value;

  modport source (output valid, kind, block_number, word_index, word_value, input ready);
  modport sink   (input valid, kind, block_number, word_index, word_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/bba_rsp_if.sv =====
`default_nettype none
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] allocated_block;
  logic [31:0] free_total;
  logic        dirty;

  modport source (output valid, status, allocated_block, free_total, dirty, input ready);
  modport sink   (input valid, status, allocated_block, free_total, dirty, output ready);
endinterface
`default_nettype wire

// ===== hdl/bba_cfg_if.sv =====
`default_nettype none
interface bba_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bba_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
`default_nettype none
module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bba_pkg::sts_t sts,
  output bba_pkg::cmd_t      cmd
);
  import bba_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_SET   = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.req_ready = 1'b1;
        if (sts.in_valid) begin
          case (sts.in_kind)
            KIND_ALLOC: state_nxt = ST_SCAN;
            KIND_FREE,
            KIND_LOAD:  state_nxt = ST_RD;
            default:    state_nxt = ST_SET;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_hit) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = ST_RESP;
        end else if (sts.scan_end) begin
          cmd.sts_set  = 1'b1;
          cmd.sts_code = STS_NO_SPACE;
          state_nxt    = ST_RESP;
        end
      end
      ST_RD: begin
        if (sts.req_kind == KIND_FREE && !sts.in_range) begin
          cmd.sts_set  = 1'b1;
          cmd.sts_code = STS_RANGE;
          state_nxt    = ST_RESP;
        end else begin
          cmd.rmw_rd = 1'b1;
          state_nxt  = ST_WR;
        end
      end
      ST_WR: begin
        cmd.rmw_wr = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_SET: begin
        cmd.set_total = 1'b1;
        state_nxt     = ST_RESP;
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/bba_dpath.sv =====
`default_nettype none
module bba_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bba_pkg::cmd_t cmd,
  output bba_pkg::sts_t      sts,
  bba_req_if.sink            in_req,
  bba_rsp_if.source          out_rsp,
  bba_cfg_if.sink            cfg_wr
);
  import bba_pkg::*;

  // Valid bits of word w for a map of c bits in use
  function automatic logic [31:0] word_mask(input logic [WADDR_W-1:0] w,
                                            input logic [CNT_W-1:0] c);
    logic [PTR_W-1:0] full;
    logic [PTR_W-1:0] wx;
    logic [31:0]      m;
    full = c[CNT_W-1:5];
    wx   = {1'b0, w};
    if (wx < full)       m = '1;
    else if (wx == full) m = (32'h1 << c[4:0]) - 32'h1;
    else                 m = '0;
    return m;
  endfunction

  logic [31:0]        mem [MAP_WORDS];

  logic [31:0]        first_block_r;
  logic [15:0]        bit_count_r;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   nwords;

  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [1:0]         req_kind_r;
  logic [9:0]         req_widx_r;
  logic [31:0]        req_wval_r;
  logic [32:0]        diff_r;

  logic [31:0]        rdata_r;
  logic               rvld_r;
  logic [WADDR_W-1:0] rtag_r;

  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [31:0]        wr_data;

  logic [31:0]        free_count_r;
  logic               dirty_r;
  logic [1:0]         res_sts_r;
  logic               grant_r;
  logic [IDX_W-1:0]   res_idx_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_block_r;
  logic [31:0]        out_total_r;
  logic               out_dirty_r;

  logic               take;
  logic               scan_issue;
  logic [31:0]        scan_masked;
  logic               scan_any;
  logic [4:0]         scan_bit;
  logic [WADDR_W-1:0] rmw_addr;
  logic [31:0]        widx32;
  logic               widx_ok;
  logic [31:0]        set_mask;
  logic               in_range;

  assign take          = cmd.req_ready & in_req.valid;
  assign in_req.ready  = cmd.req_ready;
  assign cfg_wr.ready  = 1'b1;

  // Bits in use, clamped to the map size, and words to scan
  assign count  = (32'(bit_count_r) < 32'(MAP_BITS)) ? CNT_W'(bit_count_r)
                                                     : CNT_W'(MAP_BITS);
  assign nwords = PTR_W'((count + CNT_W'(31)) >> 5);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_block_r <= '0;
      bit_count_r   <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_FIRST_BLOCK: first_block_r <= cfg_wr.data;
        CFG_BIT_COUNT:   bit_count_r   <= cfg_wr.data[15:0];
        default: ;
      endcase
    end
  end

  // Request capture; block offset taken with its borrow
  always_ff @(posedge clk) begin
    if (take) begin
      req_kind_r <= in_req.kind;
      req_widx_r <= in_req.word_index;
      req_wval_r <= in_req.word_value;
      diff_r     <= {1'b0, in_req.block_number} - {1'b0, first_block_r};
    end
  end

  // Free range check and read-modify-write operands
  assign in_range = !diff_r[32] && (diff_r[31:0] < 32'(count));
  assign widx32   = 32'(req_widx_r);
  assign widx_ok  = widx32 < 32'(MAP_WORDS);
  assign rmw_addr = (req_kind_r == KIND_FREE) ? diff_r[IDX_W-1:5] : widx32[WADDR_W-1:0];

  always_comb begin
    if (req_kind_r == KIND_FREE) set_mask = 32'h1 << diff_r[4:0];
    else if (widx_ok)            set_mask = req_wval_r & word_mask(rmw_addr, count);
    else                         set_mask = '0;
  end

  // Scan: one word read per cycle, checked on the next
  assign scan_issue  = cmd.scan_rd && (ptr_r < nwords);
  assign scan_masked = rdata_r & word_mask(rtag_r, count);
  assign scan_any    = rvld_r && (|scan_masked);

  always_comb begin
    scan_bit = '0;
    for (int b = 31; b >= 0; b--) begin
      if (scan_masked[b]) scan_bit = 5'(b);
    end
  end

  // Word pointer for the clearing pass and the scan
  always_comb begin
    ptr_nxt = ptr_r;
    if (take)                            ptr_nxt = '0;
    else if (cmd.clr_step || scan_issue) ptr_nxt = ptr_r + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ptr_r <= '0;
    else        ptr_r <= ptr_nxt;
  end

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r[WADDR_W-1:0];
    if (scan_issue) begin
      rd_en = 1'b1;
    end else if (cmd.rmw_rd) begin
      rd_en   = 1'b1;
      rd_addr = rmw_addr;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[WADDR_W-1:0];
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_commit) begin
      wr_en   = 1'b1;
      wr_addr = rtag_r;
      wr_data = rdata_r & ~(32'h1 << scan_bit);
    end else if (cmd.rmw_wr) begin
      wr_en   = 1'b1;
      wr_addr = rmw_addr;
      wr_data = rdata_r | set_mask;
    end
  end

  // Map memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
    rtag_r <= ptr_r[WADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rvld_r <= 1'b0;
    else        rvld_r <= scan_issue;
  end

  // Free total and dirty mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r <= '0;
      dirty_r      <= 1'b0;
    end else begin
      if (cmd.alloc_commit) begin
        dirty_r <= 1'b1;
        if (free_count_r != '0) free_count_r <= free_count_r - 32'd1;
      end else if (cmd.rmw_wr && req_kind_r == KIND_FREE) begin
        dirty_r <= 1'b1;
        if (free_count_r != '1) free_count_r <= free_count_r + 32'd1;
      end else if (cmd.set_total) begin
        free_count_r <= req_wval_r;
      end
    end
  end

  // Result of the request at work
  always_ff @(posedge clk) begin
    if (take) begin
      res_sts_r <= STS_DONE;
      grant_r   <= 1'b0;
    end else begin
      if (cmd.sts_set) res_sts_r <= cmd.sts_code;
      if (cmd.alloc_commit) begin
        grant_r   <= 1'b1;
        res_idx_r <= {rtag_r, scan_bit};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (cmd.out_load)   out_valid_r <= 1'b1;
    else if (out_rsp.ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_sts_r;
      out_block_r  <= grant_r ? first_block_r + 32'(res_idx_r) : 32'd0;
      out_total_r  <= free_count_r;
      out_dirty_r  <= dirty_r;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.allocated_block = out_block_r;
  assign out_rsp.free_total      = out_total_r;
  assign out_rsp.dirty           = out_dirty_r;

  // Status toward the controller
  assign sts.in_valid = in_req.valid;
  assign sts.in_kind  = in_req.kind;
  assign sts.req_kind = req_kind_r;
  assign sts.clr_last = ptr_r[WADDR_W-1:0] == WADDR_W'(MAP_WORDS - 1);
  assign sts.scan_hit = scan_any;
  assign sts.scan_end = !rvld_r && (ptr_r >= nwords);
  assign sts.in_range = in_range;
  assign sts.out_busy = out_valid_r && !out_rsp.ready;

endmodule
`default_nettype wire

// ===== hdl/block_bitmap_allocator.sv =====
`default_nettype none
// Channel   Port      Dir  Beat
// -------   -------   ---  -----------------------------------------------
// request   in_req    in   kind, block_number, word_index, word_value
// response  out_rsp   out  status, allocated_block, free_total, dirty
// config    cfg_wr    in   index (0 first_block, 1 bit_count), data
//
// One request at a time; the next is taken once the last response is loaded.
// Allocate: first-fit scan of the map words in use until a free bit is found, up to all
// 1024 words, each read through the single read port of the map.
// Free and load read-modify-write a map word; set total and out-of-range frees do not.
// After reset a clearing pass writes all 1024 map words, one per cycle; no request
// is taken during it. A stalled response holds in the output register while the next
// request is accepted; that request finishes once the slot frees.
module block_bitmap_allocator (
  input  wire logic clk,
  input  wire logic rst_n,
  bba_req_if.sink   in_req,
  bba_rsp_if.source out_rsp,
  bba_cfg_if.sink   cfg_wr
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  bba_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

endmodule
`default_nettype wire

// ===== tb/block_bitmap_allocator_tb.sv =====
module block_bitmap_allocator_tb;
  import bba_pkg::*;

  // One response beat, packed in port order
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block;
    logic [31:0] total;
    logic        dirty;
  } rsp_fields_t;

  // Shadow copy of the allocator: map, total, dirty mark and registers
  class bitmap_shadow;
    bit [31:0]   map_words [MAP_WORDS];
    bit [31:0]   free_count;
    bit          map_changed;
    bit [31:0]   first_block;
    bit [15:0]   bit_count;
    rsp_fields_t predicted_rsp [$];
    bit [31:0]   held_blocks [$];   // granted and not yet released
    int unsigned faults, checked, grants, no_space, out_of_range;

    function void write_register(logic [3:0] index, logic [31:0] data);
      if (index == CFG_FIRST_BLOCK) begin
        first_block = data;
      end else if (index == CFG_BIT_COUNT) begin
        bit_count = data[15:0];
      end
      held_blocks.delete();
    endfunction

    function int unsigned used_bits();
      return (bit_count < MAP_BITS) ? bit_count : MAP_BITS;
    endfunction

    // Update the shadow for one accepted request and queue its response
    function void apply_request(logic [1:0] kind, logic [31:0] bno,
                                logic [9:0] widx, logic [31:0] wval);
      int unsigned used;
      int unsigned i;
      bit          found;
      bit [63:0]   lo, hi;
      rsp_fields_t r;
      used = used_bits();
      r = '0;
      r.status = STS_DONE;
      found = 1'b0;
      i = 0;
      case (kind)
        KIND_ALLOC: begin
          // first fit, skipping empty words
          while (i < used && !found) begin
            if (map_words[i >> 5] == 0) i = (i | 31) + 1;
            else if (map_words[i >> 5][i & 31]) found = 1'b1;
            else i++;
          end
          if (found) begin
            map_words[i >> 5][i & 31] = 1'b0;
            r.block = first_block + i;
            if (free_count != 0) free_count--;
            map_changed = 1'b1;
            grants++;
            held_blocks.push_back(r.block);
          end else begin
            r.status = STS_NO_SPACE;
            no_space++;
          end
        end
        KIND_FREE: begin
          // range check is done without 32-bit wrap
          lo = first_block;
          hi = lo + used;
          if (bno < lo || bno >= hi) begin
            r.status = STS_RANGE;
            out_of_range++;
          end else begin
            i = bno - first_block;
            map_words[i >> 5][i & 31] = 1'b1;
            if (free_count != '1) free_count++;
            map_changed = 1'b1;
          end
        end
        KIND_LOAD: begin
          for (int b = 0; b < 32; b++) begin
            if (widx * 32 + b < used && wval[b]) map_words[widx][b] = 1'b1;
          end
        end
        default: begin
          free_count = wval;
        end
      endcase
      r.total = free_count;
      r.dirty = map_changed;
      predicted_rsp.push_back(r);
    endfunction

    function void check_response(rsp_fields_t got);
      rsp_fields_t want;
      if (predicted_rsp.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected response beat: status %0d block %h total %h dirty %0b",
                   got.status, got.block, got.total, got.dirty);
        end
        return;
      end
      want = predicted_rsp.pop_front();
      checked++;
      if (got !== want) begin
        faults++;
        if (faults <= 10) begin
          $display("response %0d: expected status %0d block %h total %h dirty %0b",
                   checked, want.status, want.block, want.total, want.dirty);
          $display("response %0d:      got status %0d block %h total %h dirty %0b",
                   checked, got.status, got.block, got.total, got.dirty);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bba_req_if in_req ();
  bba_rsp_if out_rsp ();
  bba_cfg_if cfg_wr ();

  block_bitmap_allocator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  bitmap_shadow shadow;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  requests_sent;
  int unsigned  settings_used;
  logic [31:0]  cur_first;
  int unsigned  cur_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net well past the slowest legal run
  initial begin
    #12_000_000;
    $display("block_bitmap_allocator_tb: errors");
    $finish;
  end

  // Response side: check each beat, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready) begin
      shadow.check_response({out_rsp.status, out_rsp.allocated_block,
                             out_rsp.free_total, out_rsp.dirty});
    end
    out_rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Drive one request beat, with a random gap in front of it
  task automatic send_request(logic [1:0] kind, logic [31:0] bno,
                              logic [9:0] widx, logic [31:0] wval);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_req.valid        <= 1'b1;
    in_req.kind         <= kind;
    in_req.block_number <= bno;
    in_req.word_index   <= widx;
    in_req.word_value   <= wval;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    shadow.apply_request(kind, bno, widx, wval);
    requests_sent++;
  endtask

  // Write both registers once the block has drained
  task automatic configure(logic [31:0] first, logic [15:0] count);
    in_req.valid <= 1'b0;
    while (shadow.predicted_rsp.size() != 0) @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= CFG_FIRST_BLOCK;
    cfg_wr.data  <= first;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    shadow.write_register(CFG_FIRST_BLOCK, first);
    cfg_wr.index <= CFG_BIT_COUNT;
    cfg_wr.data  <= {16'h0, count};
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    shadow.write_register(CFG_BIT_COUNT, {16'h0, count});
    cfg_wr.valid <= 1'b0;
    cur_first = first;
    cur_used  = shadow.used_bits();
    settings_used++;
  endtask

  // Mostly well-formed traffic: grants released again, loads inside the map
  task automatic random_request();
    int unsigned pick, words, n;
    logic [1:0]  kind;
    logic [31:0] bno, wval;
    logic [9:0]  widx;
    pick  = $urandom_range(0, 99);
    bno   = $urandom;
    widx  = 10'($urandom_range(0, 1023));
    wval  = $urandom;
    words = (cur_used + 31) / 32;
    if (pick < 35) begin
      kind = KIND_ALLOC;
    end else if (pick < 65) begin
      kind = KIND_FREE;
      pick = $urandom_range(0, 99);
      n = shadow.held_blocks.size();
      if (pick < 45 && n != 0) begin
        n = $urandom_range(0, n - 1);
        bno = shadow.held_blocks[n];
        shadow.held_blocks.delete(n);
      end else if (pick < 80 && cur_used != 0) begin
        bno = cur_first + $urandom_range(0, cur_used - 1);
      end else if (pick < 90) begin
        bno = $urandom_range(0, 1) ? cur_first - 1 : cur_first + cur_used;
      end
    end else if (pick < 85) begin
      kind = KIND_LOAD;
      if ($urandom_range(0, 99) < 75 && words != 0) widx = 10'($urandom_range(0, words - 1));
      case ($urandom_range(0, 3))
        0:       wval = $urandom & $urandom;
        1:       wval = '1;
        default: ;
      endcase
    end else begin
      kind = KIND_TOTAL;
      case ($urandom_range(0, 3))
        0:       wval = '0;
        1:       wval = '1;
        2:       wval = $urandom_range(0, 8);
        default: ;
      endcase
    end
    send_request(kind, bno, widx, wval);
  endtask

  initial begin
    logic [31:0] first;
    logic [15:0] count;
    int unsigned items;
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.kind         = KIND_ALLOC;
    in_req.block_number = '0;
    in_req.word_index   = '0;
    in_req.word_value   = '0;
    cfg_wr.valid        = 1'b0;
    cfg_wr.index        = CFG_FIRST_BLOCK;
    cfg_wr.data         = '0;
    out_rsp.ready       = 1'b0;
    tx_idle_pct         = 17;
    rx_idle_pct         = 80;
    requests_sent       = 0;
    settings_used       = 0;
    shadow              = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Count above map size, one free bit at the very top: full scans
    configure(32'hFFFF_FFFF, 16'hFFFF);
    send_request(KIND_LOAD, '0, 10'd1023, 32'h8000_0000);
    send_request(KIND_ALLOC, '0, '0, '0);           // zero total stays zero
    send_request(KIND_ALLOC, '0, '0, '0);           // nothing left
    send_request(KIND_FREE, 32'hFFFF_FFFF, '0, '0);
    send_request(KIND_FREE, 32'h0, '0, '0);         // below first block

    // Empty map window
    configure(32'h0, 16'd0);
    send_request(KIND_ALLOC, '0, '0, '0);
    send_request(KIND_FREE, 32'h0, '0, '0);
    send_request(KIND_LOAD, '0, 10'd0, 32'hFFFF_FFFF);
    send_request(KIND_TOTAL, '0, '0, 32'hFFFF_FFFF);

    // Window near the top of the block space: saturation and wrapped grants
    configure(32'hFFFF_FFF0, 16'd40);
    send_request(KIND_TOTAL, '0, '0, 32'hFFFF_FFFE);
    send_request(KIND_FREE, 32'hFFFF_FFFF, '0, '0);
    send_request(KIND_FREE, 32'hFFFF_FFFF, '0, '0); // already free, total saturates
    send_request(KIND_LOAD, '0, 10'd0, 32'hFFFF_0000);
    send_request(KIND_LOAD, '0, 10'd1, 32'hFFFF_FFFF); // only 8 bits in use
    send_request(KIND_TOTAL, '0, '0, 32'h0);
    send_request(KIND_ALLOC, '0, '0, '0);
    send_request(KIND_ALLOC, '0, '0, '0);
    send_request(KIND_ALLOC, '0, '0, '0);           // grant wraps past zero, to block one
    send_request(KIND_FREE, 32'h0, '0, '0);         // wrapped block is out of range
    send_request(KIND_LOAD, '0, 10'd1023, 32'hFFFF_FFFF);
    send_request(KIND_FREE, 32'hFFFF_FFEF, '0, '0);
    send_request(KIND_ALLOC, '0, 10'd1023, 32'h5555_AAAA);

    // Random traffic over several windows
    for (int p = 0; p < 8; p++) begin
      items = 75;
      case (p)
        0:       begin first = $urandom;       count = 16'd64;  end
        1:       begin first = 32'h0;          count = 16'd1;   end
        2:       begin first = 32'hFFFF_FF00;  count = 16'd300; end
        3:       begin first = $urandom;       count = 16'd32;  end
        4:       begin first = $urandom;       count = 16'd33;  end
        5:       begin first = 32'd1000;       count = 16'd700; end
        6:       begin first = 32'hFFFF_FFFF;  count = 16'h8000; items = 30; end
        default: begin first = $urandom;       count = 16'($urandom_range(2, 200)); end
      endcase
      if (p == 2) begin
        tx_idle_pct = 80;
        rx_idle_pct = 17;
      end else if (p == 5) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      configure(first, count);
      repeat (items) random_request();
    end

    // Drain, then watch for stray beats
    in_req.valid <= 1'b0;
    while (shadow.predicted_rsp.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);

    $display("%0d requests over %0d window settings, %0d responses checked",
             requests_sent, settings_used, shadow.checked);
    $display("%0d grants, %0d no-space allocates, %0d out-of-range frees, %0d mismatches",
             shadow.grants, shadow.no_space, shadow.out_of_range, shadow.faults);
    if (shadow.faults == 0 && shadow.predicted_rsp.size() == 0) begin
      $display("block_bitmap_allocator_tb: clean");
    end else begin
      $display("block_bitmap_allocator_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bba_pkg.sv
hdl/bba_req_if.sv
hdl/bba_rsp_if.sv
hdl/bba_cfg_if.sv
hdl/bba_ctrl.sv
hdl/bba_dpath.sv
hdl/block_bitmap_allocator.sv
tb/block_bitmap_allocator_tb.sv
